@@ sv/gcsf_pkg.sv @@
// ----------------------------------------------------------------------------
// gcsf_pkg - shared types and constants of the compatible-set filter
// Command and status codes, cell control bundle, field widths and defaults.
// ----------------------------------------------------------------------------
package gcsf_pkg;

  localparam int WORD_W            = 64;
  localparam int CMD_W             = 2;
  localparam int STATUS_W          = 3;
  localparam int BUDGET_W          = 9;
  localparam int FLAG_W            = 3;
  localparam int GROUP_SIZE        = 16;
  localparam int DEF_TABLE_ENTRIES = 256;
  localparam int DEF_MASK_WORDS    = 4;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(256);

  // per-entry flag bits
  localparam int FLAG_DISJOINT = 0;  // no common member so far
  localparam int FLAG_CAND_SUB = 1;  // incoming row within stored row so far
  localparam int FLAG_OLD_SUB  = 2;  // stored row within incoming row so far

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR     = 2'd0,
    CMD_PRELOAD   = 2'd1,
    CMD_CANDIDATE = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_ACCEPTED   = 3'd0,
    STATUS_PRELOADED  = 3'd1,
    STATUS_CONFLICT   = 3'd2,
    STATUS_NO_BUDGET  = 3'd3,
    STATUS_TABLE_FULL = 3'd4
  } status_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp;      // compare the broadcast word this cycle
    logic row_end;  // broadcast word closes the row; words above count as zero
    logic restart;  // set flags back to all ones
    logic shift;    // take row and valid from the left neighbor
    logic clear;    // drop every stored row
  } cell_ctl_t;

endpackage

@@ sv/greedy_compatible_set_filter.sv @@
// ----------------------------------------------------------------------------
// greedy_compatible_set_filter - greedy compatible-set filter, top level
// Sequencer, row buffer, chain of entry cells, registered conflict reduction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one mask word per transfer:
//   command, mask_word, last_word. A row is up to MASK_WORDS words, lowest
//   first; it ends on last_word or on its MASK_WORDS-th word. Clear empties
//   the table and zeroes the accept count; code 3 is ignored.
//   Every stored row sits in a cell that compares the broadcast word against
//   its own word at once, so a word that does not end a row is taken without
//   stalling. A row-ending word holds in_stall high through S_REDUCE, which
//   registers per-group conflict ORs (GROUP_SIZE cells each), and S_DECIDE,
//   which decides; the row's result is registered onto the output channel
//   (out_valid / out_stall: status, accepted). Other words give no result.
//   If the receiver stalls, the result holds; the next row is taken in and
//   compared, and its decision waits until the output register is free.
//   accept_budget is written through cfg_we / cfg_wdata; the user must do
//   so only while idle, and the block itself does not enforce this.
//   Reset (rst, synchronous): empty table, zero counts, budget 256. No
//   clearing pass; valid bits live in the cells.
// ----------------------------------------------------------------------------
module greedy_compatible_set_filter import gcsf_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int MASK_WORDS    = DEF_MASK_WORDS
) (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_we,
  input  logic [BUDGET_W-1:0] cfg_wdata,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    command,
  input  logic [WORD_W-1:0]   mask_word,
  input  logic                last_word,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic                accepted
);

  localparam int POS_W      = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;
  localparam int CNT_W      = $clog2(TABLE_ENTRIES + 1);
  localparam int ROW_W      = MASK_WORDS * WORD_W;
  localparam int NUM_GROUPS = (TABLE_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PAD_W      = NUM_GROUPS * GROUP_SIZE;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_REDUCE = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [BUDGET_W-1:0] accept_budget;
  logic [CNT_W-1:0]    entry_count;
  logic [BUDGET_W-1:0] new_accept_count;
  logic [POS_W-1:0]    word_position;
  logic [WORD_W-1:0]   cand_buf [MASK_WORDS];
  logic [ROW_W-1:0]    row_hold;
  cmd_t                row_cmd;

  cmd_t                cmd;
  logic                in_xfer;
  logic                word_xfer;
  logic                row_end;
  logic                decide;
  logic                store;
  logic                table_full;
  logic                any_conflict;
  status_t             status_next;
  logic [MASK_WORDS-1:0] sel;
  logic [MASK_WORDS-1:0] above;
  logic [ROW_W-1:0]    row_asm;
  cell_ctl_t           ctl;

  logic [ROW_W-1:0]         cell_row [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] cell_valid;
  logic [TABLE_ENTRIES-1:0] cell_conf;
  logic [PAD_W-1:0]         conf_pad;
  logic [NUM_GROUPS-1:0]    group_conf;

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  assign cmd       = cmd_t'(command);
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign word_xfer = in_xfer && ((cmd == CMD_PRELOAD) || (cmd == CMD_CANDIDATE));
  assign row_end   = last_word || (word_position == POS_W'(MASK_WORDS - 1));

  // word select, words above the current one, and the row as it would close now
  always_comb begin
    for (int w = 0; w < MASK_WORDS; w++) begin
      sel[w]   = (word_position == POS_W'(w));
      above[w] = (POS_W'(w) > word_position);
      if (sel[w]) begin
        row_asm[w*WORD_W +: WORD_W] = mask_word;
      end else if (above[w]) begin
        row_asm[w*WORD_W +: WORD_W] = '0;
      end else begin
        row_asm[w*WORD_W +: WORD_W] = cand_buf[w];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (word_xfer) begin
      cand_buf[word_position] <= mask_word;
      if (row_end) begin
        row_hold <= row_asm;
        row_cmd  <= cmd;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Decision
  // --------------------------------------------------------------------------
  assign decide       = (state == S_DECIDE) && (!out_valid || !out_stall);
  assign table_full   = (entry_count == CNT_W'(TABLE_ENTRIES));
  assign any_conflict = |group_conf;

  always_comb begin
    store       = 1'b0;
    status_next = STATUS_TABLE_FULL;
    if (row_cmd == CMD_PRELOAD) begin
      if (!table_full) begin
        store       = 1'b1;
        status_next = STATUS_PRELOADED;
      end
    end else begin
      priority if (new_accept_count >= accept_budget) begin
        status_next = STATUS_NO_BUDGET;
      end else if (any_conflict) begin
        status_next = STATUS_CONFLICT;
      end else if (table_full) begin
        status_next = STATUS_TABLE_FULL;
      end else begin
        store       = 1'b1;
        status_next = STATUS_ACCEPTED;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (word_xfer && row_end) state_next = S_REDUCE;
      end
      S_REDUCE: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (decide) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      accept_budget    <= BUDGET_RESET;
      entry_count      <= '0;
      new_accept_count <= '0;
      word_position    <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        accept_budget <= cfg_wdata;
      end
      if (in_xfer && (cmd == CMD_CLEAR)) begin
        entry_count      <= '0;
        new_accept_count <= '0;
        word_position    <= '0;
      end else if (word_xfer) begin
        word_position <= row_end ? '0 : word_position + 1'b1;
      end
      if (decide && store) begin
        entry_count <= entry_count + 1'b1;
        if (row_cmd == CMD_CANDIDATE) begin
          new_accept_count <= new_accept_count + 1'b1;
        end
      end
      if (decide) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (decide) begin
      status   <= status_next;
      accepted <= (status_next == STATUS_ACCEPTED);
    end
  end

  // --------------------------------------------------------------------------
  // Cell chain: new rows enter at cell 0 and push the rest one place along;
  // entry order does not matter to the check, only the count does.
  // --------------------------------------------------------------------------
  assign ctl.cmp     = word_xfer;
  assign ctl.row_end = row_end;
  assign ctl.clear   = in_xfer && (cmd == CMD_CLEAR);
  assign ctl.restart = ctl.clear || decide;
  assign ctl.shift   = decide && store;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    logic [ROW_W-1:0] row_left;
    logic             valid_left;

    if (i == 0) begin : g_head
      assign row_left   = row_hold;
      assign valid_left = 1'b1;
    end else begin : g_link
      assign row_left   = cell_row[i-1];
      assign valid_left = cell_valid[i-1];
    end

    gcsf_cell #(
      .MASK_WORDS (MASK_WORDS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .sel       (sel),
      .above     (above),
      .word      (mask_word),
      .row_in    (row_left),
      .valid_in  (valid_left),
      .row_out   (cell_row[i]),
      .valid_out (cell_valid[i]),
      .conflict  (cell_conf[i])
    );
  end

  // conflict reduction, first level registered per group of cells
  assign conf_pad = PAD_W'(cell_conf);

  always_ff @(posedge clk) begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_conf[g] <= |conf_pad[g*GROUP_SIZE +: GROUP_SIZE];
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(entry_count))
    else $error("valid cells disagree with entry count");

  a_accepts_within_table: assert property (@(posedge clk) disable iff (rst)
    int'(new_accept_count) <= int'(entry_count))
    else $error("accept count exceeds stored rows");

  a_result_after_decide: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(state == S_DECIDE))
    else $error("result raised outside the decision step");

  a_no_input_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_REDUCE) |=> (state == S_DECIDE) && in_stall)
    else $error("reduction did not lead to a decision");
`endif

endmodule

@@ sv/gcsf_cell.sv @@
// ----------------------------------------------------------------------------
// gcsf_cell - one table entry of the compatible-set filter
// Holds a stored row, its valid bit and its running relation flags.
// ----------------------------------------------------------------------------
module gcsf_cell import gcsf_pkg::*; #(
  parameter int MASK_WORDS = DEF_MASK_WORDS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cell_ctl_t                    ctl,
  input  logic [MASK_WORDS-1:0]        sel,
  input  logic [MASK_WORDS-1:0]        above,
  input  logic [WORD_W-1:0]            word,
  input  logic [MASK_WORDS*WORD_W-1:0] row_in,
  input  logic                         valid_in,
  output logic [MASK_WORDS*WORD_W-1:0] row_out,
  output logic                         valid_out,
  output logic                         conflict
);

  logic [MASK_WORDS*WORD_W-1:0] row;
  logic                         valid;
  logic [FLAG_W-1:0]            flags;
  logic [FLAG_W-1:0]            flags_next;
  logic [WORD_W-1:0]            stored_word;
  logic [WORD_W-1:0]            both;
  logic [MASK_WORDS-1:0]        nz;

  always_comb begin
    stored_word = '0;
    for (int w = 0; w < MASK_WORDS; w++) begin
      nz[w] = |row[w*WORD_W +: WORD_W];
      if (sel[w]) begin
        stored_word = row[w*WORD_W +: WORD_W];
      end
    end
  end

  assign both = word & stored_word;

  always_comb begin
    flags_next = flags;
    if (ctl.restart) begin
      flags_next = '1;
    end else if (ctl.cmp) begin
      if (both != '0)          flags_next[FLAG_DISJOINT] = 1'b0;
      if (both != word)        flags_next[FLAG_CAND_SUB] = 1'b0;
      if (both != stored_word) flags_next[FLAG_OLD_SUB]  = 1'b0;
      // zero padding of a short row: stored nonzero words above break old-in-new
      if (ctl.row_end && ((nz & above) != '0)) flags_next[FLAG_OLD_SUB] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '1;
      valid <= 1'b0;
    end else begin
      flags <= flags_next;
      if (ctl.clear) begin
        valid <= 1'b0;
      end else if (ctl.shift) begin
        valid <= valid_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      row <= row_in;
    end
  end

  assign row_out   = row;
  assign valid_out = valid;
  assign conflict  = valid && (flags == '0);

endmodule

@@ dv/greedy_compatible_set_filter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_compatible_set_filter_test - self-checking bench of the set filter
// Streams mask words into the filter and keeps a row table of its own to
// predict every verdict. Verdicts are compared field by field in order while
// both channels idle and stall at random and accept_budget moves between
// phases.
// ----------------------------------------------------------------------------
module greedy_compatible_set_filter_test;
  import gcsf_pkg::*;

  localparam int N_ROWS        = DEF_TABLE_ENTRIES;
  localparam int N_WORDS       = DEF_MASK_WORDS;
  localparam int SETTLE_CYCLES = 8;    // row end stall plus result latency, with margin
  localparam int LONG_HOLD     = 300;  // receiver hold-off that backs up the filter

  typedef logic [N_WORDS-1:0][WORD_W-1:0] row_t;

  typedef struct {
    status_t st;
    logic    acc;
  } verdict_t;

  // Row table predictor and queue of pending verdicts.
  class verdict_board;
    row_t              rows [N_ROWS];
    logic [FLAG_W-1:0] rel [N_ROWS];   // relation of incoming row to each stored row
    int unsigned       n_rows;
    int unsigned       n_taken;        // candidates accepted since the last clear
    int unsigned       word_idx;
    row_t              incoming;
    logic [BUDGET_W-1:0] budget;
    verdict_t          verdict_q [$];
    int                errors;

    function new();
      budget = BUDGET_RESET;
      errors = 0;
      clear_table();
    endfunction

    function void restart_row();
      word_idx = 0;
      foreach (rel[e]) rel[e] = '1;
    endfunction

    function void clear_table();
      n_rows  = 0;
      n_taken = 0;
      restart_row();
    endfunction

    function void fold_word(int unsigned pos, logic [WORD_W-1:0] cw);
      logic [WORD_W-1:0] both;
      int unsigned e;
      for (e = 0; e < n_rows; e++) begin
        both = cw & rows[e][pos];
        if (both != '0) rel[e][FLAG_DISJOINT] = 1'b0;
        if (both != cw) rel[e][FLAG_CAND_SUB] = 1'b0;
        if (both != rows[e][pos]) rel[e][FLAG_OLD_SUB] = 1'b0;
      end
    endfunction

    // Called for every accepted input transfer.
    function void take_word(cmd_t c, logic [WORD_W-1:0] w, logic l);
      int unsigned pos, k, e;
      bit fits;
      verdict_t v;
      if (c == CMD_CLEAR) begin
        clear_table();
        return;
      end
      if (c == CMD_UNUSED) return;
      pos = (word_idx >= N_WORDS) ? N_WORDS - 1 : word_idx;
      incoming[pos] = w;
      fold_word(pos, w);
      if (!l && pos + 1 < N_WORDS) begin
        word_idx = pos + 1;
        return;
      end
      // row closes; missing upper words are zero
      for (k = pos + 1; k < N_WORDS; k++) begin
        incoming[k] = '0;
        fold_word(k, '0);
      end
      if (c == CMD_PRELOAD) begin
        if (n_rows < N_ROWS) begin
          rows[n_rows] = incoming;
          n_rows++;
          v.st = STATUS_PRELOADED;
        end else begin
          v.st = STATUS_TABLE_FULL;
        end
      end else begin
        fits = 1'b1;
        for (e = 0; e < n_rows; e++)
          if (rel[e] == '0) fits = 1'b0;
        if (n_taken >= budget) begin
          v.st = STATUS_NO_BUDGET;
        end else if (!fits) begin
          v.st = STATUS_CONFLICT;
        end else if (n_rows >= N_ROWS) begin
          v.st = STATUS_TABLE_FULL;
        end else begin
          rows[n_rows] = incoming;
          n_rows++;
          n_taken++;
          v.st = STATUS_ACCEPTED;
        end
      end
      v.acc = (v.st == STATUS_ACCEPTED);
      verdict_q = {verdict_q, v};
      restart_row();
    endfunction

    // Called for every accepted output transfer.
    function void check_verdict(logic [STATUS_W-1:0] st, logic acc);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: verdict with none pending: status %0d accepted %0d", $time, st, acc);
        return;
      end
      v = verdict_q.pop_front();
      if (st !== v.st) begin
        errors++;
        $display("%0t: status mismatch: expected %0d actual %0d", $time, v.st, st);
      end
      if (acc !== v.acc) begin
        errors++;
        $display("%0t: accepted mismatch: expected %0d actual %0d", $time, v.acc, acc);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, stimulus signals and the block
  // --------------------------------------------------------------------------
  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [BUDGET_W-1:0] cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    command   = CMD_CLEAR;
  logic [WORD_W-1:0]   mask_word = '0;
  logic                last_word = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic                accepted;

  verdict_board board;
  bit tx_idle    = 1'b0;  // sender draws gaps when set
  bit rx_idle    = 1'b0;  // receiver draws stalls when set
  int hold_left  = 0;
  int n_results  = 0;
  int n_sent     = 0;     // transfers that the filter acts on

  always #1 clk = ~clk;

  greedy_compatible_set_filter i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .mask_word (mask_word),
    .last_word (last_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .accepted  (accepted)
  );

  // Hard stop in case the filter hangs.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: stall is driven on the falling edge, transfers are taken on the
  // rising edge. After each transfer a new hold-off is drawn; the 40th
  // transfer triggers one long hold so the filter backs up into in_stall.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_verdict(status, accepted);
      n_results++;
      if (n_results == 40) hold_left = LONG_HOLD;
      else hold_left = rx_idle ? $urandom_range(0, 5) : 0;
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic row_t rand_row();
    row_t r;
    for (int w = 0; w < N_WORDS; w++) r[w] = rand_word();
    return r;
  endfunction

  // One word transfer: optional gap, then hold the payload until taken.
  // valid is only lowered during a gap, so back-to-back words keep it high.
  task automatic send_word(cmd_t c, logic [WORD_W-1:0] w, logic l);
    int gap;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    command   <= c;
    mask_word <= w;
    last_word <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_word(c, w, l);
    if (c != CMD_UNUSED) n_sent++;
  endtask

  // Stop offering, wait for every pending verdict, then let the pipe settle
  // so a row that gave no verdict is done before the next register write.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_budget(logic [BUDGET_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    board.budget = v;
  endtask

  // Candidate rows built from the current table so that a fair share of them
  // is compatible: copies, subsets and unions of stored rows, full and empty
  // rows, plus some plain random rows that almost always conflict.
  function automatic row_t make_row();
    row_t r, a, b;
    int kind;
    a = (board.n_rows != 0) ? board.rows[$urandom_range(0, board.n_rows - 1)] : '0;
    b = (board.n_rows != 0) ? board.rows[$urandom_range(0, board.n_rows - 1)] : '0;
    kind = $urandom_range(0, 9);
    case (kind)
      0: r = '0;
      1: r = a;
      2, 3: r = a & rand_row();
      4: r = a | b;
      5: begin
        r = '0;
        r[$urandom_range(0, N_WORDS - 1)][$urandom_range(0, WORD_W - 1)] = 1'b1;
      end
      6: r = rand_row();
      7: r = '1;
      8: r = a | (rand_row() & rand_row() & rand_row());
      default: r = ~a & rand_row();
    endcase
    return r;
  endfunction

  // Sends the first nw words of a row. Mixed rows change the command on all
  // but the last word; ignored code-3 words and rare clears land inside rows too.
  task automatic send_row(cmd_t c, row_t r, int nw, logic mark, bit mixed);
    cmd_t wc;
    for (int k = 0; k < nw; k++) begin
      if ($urandom_range(0, 19) == 0)
        send_word(CMD_UNUSED, rand_word(), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 59) == 0)
        send_word(CMD_CLEAR, rand_word(), 1'($urandom_range(0, 1)));
      wc = c;
      if (mixed && k < nw - 1) wc = $urandom_range(0, 1) ? CMD_PRELOAD : CMD_CANDIDATE;
      send_word(wc, r[k], (k == nw - 1) ? mark : 1'b0);
    end
  endtask

  task automatic run_random(int n_items);
    int start, pick, nw;
    logic mark;
    cmd_t c;
    start = n_sent;
    while (n_sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_word(CMD_CLEAR, rand_word(), 1'($urandom_range(0, 1)));
      end else begin
        c  = (pick < 30) ? CMD_PRELOAD : CMD_CANDIDATE;
        nw = $urandom_range(1, N_WORDS);
        // short rows nearly always marked; a full row may end unmarked
        mark = (nw < N_WORDS) ? ($urandom_range(0, 15) != 0) : 1'($urandom_range(0, 1));
        send_row(c, make_row(), nw, mark, $urandom_range(0, 9) == 0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int plan [9];
    logic [WORD_W-1:0] one_hot;
    plan  = '{0, 256, 1, 3, 256, -1, -1, -1, 2};  // -1 picks a random budget
    board = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, reset budget.
    send_word(CMD_UNUSED, '1, 1'b1);               // ignored
    send_word(CMD_CLEAR, '1, 1'b1);
    send_word(CMD_PRELOAD, 64'hFF, 1'b1);          // short row stored
    send_word(CMD_CANDIDATE, 64'h0F, 1'b1);        // subset: accepted
    send_word(CMD_CANDIDATE, 64'hFF00, 1'b1);      // disjoint: accepted
    send_word(CMD_CANDIDATE, 64'h0FF0, 1'b1);      // straddles 0xFF: conflict
    repeat (N_WORDS) send_word(CMD_CANDIDATE, '1, 1'b0);  // long row ends itself
    send_word(CMD_CANDIDATE, '0, 1'b0);
    send_word(CMD_CANDIDATE, 64'h1, 1'b1);         // two-word row: accepted
    send_word(CMD_CANDIDATE, 64'h3, 1'b0);
    send_word(CMD_PRELOAD, '0, 1'b1);              // mixed, ends as preload
    send_word(CMD_PRELOAD, 64'h18, 1'b0);
    send_word(CMD_CANDIDATE, 64'h8000_0000_0000_0000, 1'b1);  // mixed, conflict
    send_word(CMD_CANDIDATE, 64'h1, 1'b0);
    send_word(CMD_CLEAR, '0, 1'b0);                // clear inside a row
    send_word(CMD_CANDIDATE, '1, 1'b1);            // empty table: accepted
    send_word(CMD_CANDIDATE, 64'h5, 1'b0);
    send_word(CMD_UNUSED, '0, 1'b1);               // ignored inside a row
    send_word(CMD_CANDIDATE, 64'h4, 1'b1);         // conflict
    drain();

    // Random phases, each with its own budget and idling mix.
    foreach (plan[p]) begin
      write_budget((plan[p] < 0) ? BUDGET_W'($urandom_range(0, 256)) : BUDGET_W'(plan[p]));
      tx_idle = (p != 1) && ($urandom_range(0, 3) != 0);
      rx_idle = (p != 1) && ($urandom_range(0, 3) != 0);
      send_word(CMD_CLEAR, '0, 1'b0);
      run_random(190);
      drain();
    end

    // Fill the table: one two-bit row, then singletons, then candidates.
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    write_budget(BUDGET_W'(256));
    send_word(CMD_CLEAR, '0, 1'b1);
    send_word(CMD_PRELOAD, 64'h3, 1'b1);
    for (int i = 1; i < N_ROWS - 6; i++) begin
      one_hot = '0;
      one_hot[i % WORD_W] = 1'b1;
      send_word(CMD_PRELOAD, one_hot, 1'b1);
    end
    repeat (8) send_word(CMD_CANDIDATE, '0, 1'b1);  // accepted until full
    send_word(CMD_CANDIDATE, 64'h6, 1'b1);          // conflict wins over full
    send_word(CMD_CANDIDATE, '1, 1'b1);             // full
    send_word(CMD_PRELOAD, '1, 1'b1);               // full, row dropped
    drain();
    write_budget('0);
    send_word(CMD_CANDIDATE, 64'h6, 1'b1);          // budget wins over all
    send_word(CMD_PRELOAD, '0, 1'b1);
    drain();

    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/gcsf_pkg.sv
sv/gcsf_cell.sv
sv/greedy_compatible_set_filter.sv
dv/greedy_compatible_set_filter_test.sv
